>>> rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the segment carver RTL.
// No dependencies. Define SYNTH to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("segment carver assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment carver assertion failed");
`else
`define SRC_ASSERT(lbl, clk, rst_n, prop)
`define SRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/src_pkg.sv
// src_pkg: shared types and constants of the segment range carver.
// No dependencies; used by the controller, the datapath and the top level.
package src_pkg;

    // Default depth of the segment table.
    localparam int MAX_SEGMENTS_DEF = 256;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FIT    = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    // One table entry as stored in the segment memory.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        used;
    } entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_SCAN,
        S_EVAL,
        S_SHIFT,
        S_FLUSH,
        S_WR_PRE,
        S_WR_USED,
        S_WR_REST,
        S_READ,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    init_table;
        logic    start_item;
        logic    scan_init;
        logic    scan_step;
        logic    shift_init;
        logic    shift_step;
        logic    wr_pre;
        logic    wr_used;
        logic    wr_rest;
        logic    commit;
        logic    rd_issue;
        logic    load_out;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic len_zero;
        logic hit;
        logic exhausted;
        logic late;
        logic full;
        logic need_shift;
        logic shift_last;
        logic do_pre;
        logic do_rest;
        logic idx_ok;
    } stat_t;

endpackage

>>> rtl/src_req_if.sv
// src_req_if: request channel of the segment range carver.
// No dependencies.
interface src_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] range_start;
    logic [31:0] range_length;
    logic [7:0]  entry_index;

    modport source (output valid, kind, range_start, range_length, entry_index,
                    input ready);
    modport sink (input valid, kind, range_start, range_length, entry_index,
                  output ready);
endinterface

>>> rtl/src_res_if.sv
// src_res_if: result channel of the segment range carver.
// No dependencies.
interface src_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  new_slot;
    logic [8:0]  entry_count;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic        entry_used;

    modport source (output valid, status, new_slot, entry_count, entry_start,
                    entry_length, entry_used, input ready);
    modport sink (input valid, status, new_slot, entry_count, entry_start,
                  entry_length, entry_used, output ready);
endinterface

>>> rtl/src_cfg_if.sv
// src_cfg_if: configuration write channel carrying the region size.
// No dependencies.
interface src_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] region_size;

    modport source (output valid, region_size, input ready);
    modport sink (input valid, region_size, output ready);
endinterface

>>> rtl/src_datapath.sv
// src_datapath: segment memory, scan and shift pointers, split arithmetic
// and the result register. Depends on src_pkg and assert_macros.svh.
`include "assert_macros.svh"

module src_datapath #(
    parameter int MAX_SEGMENTS = src_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  src_pkg::cmd_t        cmd,
    output src_pkg::stat_t       stat,
    input  logic                 cfg_write,
    input  logic [31:0]          cfg_region_size,
    input  logic                 in_kind,
    input  logic [31:0]          in_range_start,
    input  logic [31:0]          in_range_length,
    input  logic [7:0]           in_entry_index,
    output logic [1:0]           status,
    output logic [7:0]           new_slot,
    output logic [8:0]           entry_count,
    output logic [31:0]          entry_start,
    output logic [31:0]          entry_length,
    output logic                 entry_used
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // Segment table storage.
    src_pkg::entry_t seg_mem [MAX_SEGMENTS];
    src_pkg::entry_t rd_data_reg;

    // Control registers.
    logic [31:0]   region_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_ptr_reg;
    logic          chk_vld_reg;
    logic          wpend_reg;

    // Item and working registers.
    logic          kind_reg;
    logic [31:0]   off_reg;
    logic [31:0]   len_reg;
    logic [7:0]    idx_reg;
    logic [IW-1:0] chk_ptr_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]   hit_start_reg;
    logic [32:0]   hit_end_reg;
    logic [IW-1:0] rp_reg;
    logic [IW-1:0] wa_reg;

    // Result register.
    src_pkg::status_t out_status_reg;
    logic [7:0]       out_slot_reg;
    logic [8:0]       out_count_reg;
    src_pkg::entry_t  out_entry_reg;

    // Derived values.
    logic [32:0]     want_end;
    logic [32:0]     rd_end;
    logic [32:0]     rest;
    logic [1:0]      net;
    logic [IW-1:0]   used_slot;
    logic            scan_more;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    src_pkg::entry_t wr_data;
    logic            res_ok;

    // Split arithmetic on the latched covering segment.
    always_comb
    begin
        want_end  = {1'b0, off_reg} + {1'b0, len_reg};
        rd_end    = {1'b0, rd_data_reg.start} + {1'b0, rd_data_reg.length};
        rest      = hit_end_reg - want_end;
        net       = {1'b0, hit_start_reg < off_reg} + {1'b0, rest != 33'd0};
        used_slot = hit_idx_reg + IW'(hit_start_reg < off_reg);
        scan_more = scan_ptr_reg < count_reg;
    end

    // Status toward the controller.
    always_comb
    begin
        stat.kind       = kind_reg;
        stat.len_zero   = (len_reg == 32'd0);
        stat.hit        = chk_vld_reg && !rd_data_reg.used && (rd_end >= want_end);
        stat.exhausted  = !chk_vld_reg && !scan_more;
        stat.late       = hit_start_reg > off_reg;
        stat.do_pre     = hit_start_reg < off_reg;
        stat.do_rest    = rest != 33'd0;
        stat.full       = ((CW + 1)'(count_reg) + (CW + 1)'(net)) >
                          (CW + 1)'(MAX_SEGMENTS);
        stat.need_shift = (net != 2'd0) && ((CW'(hit_idx_reg) + CW'(1)) < count_reg);
        stat.shift_last = rp_reg == (hit_idx_reg + IW'(1));
        stat.idx_ok     = 32'(idx_reg) < 32'(count_reg);
    end

    // Read port address select.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.scan_step && scan_more)
        begin
            rd_en   = 1'b1;
            rd_addr = scan_ptr_reg[IW-1:0];
        end
        else if (cmd.shift_step)
        begin
            rd_en   = 1'b1;
            rd_addr = rp_reg;
        end
        else if (cmd.rd_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = IW'(idx_reg);
        end
    end

    // Write port select: restart, shifted entry, or one of the split pieces.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.init_table)
        begin
            wr_en   = 1'b1;
            wr_data = '{start: 32'd0, length: region_reg, used: 1'b0};
        end
        else if (wpend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wa_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.wr_pre)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = '{start: hit_start_reg, length: off_reg - hit_start_reg, used: 1'b0};
        end
        else if (cmd.wr_used)
        begin
            wr_en   = 1'b1;
            wr_addr = used_slot;
            wr_data = '{start: off_reg, length: len_reg, used: 1'b1};
        end
        else if (cmd.wr_rest)
        begin
            wr_en   = 1'b1;
            wr_addr = used_slot + IW'(1);
            wr_data = '{start: want_end[31:0], length: rest[31:0], used: 1'b0};
        end
    end

    // Segment memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= seg_mem[rd_addr];
        end
    end

    // Control registers: region size, entry count, scan and shift tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg   <= 32'd0;
            count_reg    <= CW'(1);
            scan_ptr_reg <= '0;
            chk_vld_reg  <= 1'b0;
            wpend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                region_reg <= cfg_region_size;
            end
            if (cmd.init_table)
            begin
                count_reg <= CW'(1);
            end
            else if (cmd.commit)
            begin
                count_reg <= count_reg + CW'(net);
            end
            if (cmd.scan_init)
            begin
                scan_ptr_reg <= '0;
                chk_vld_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_vld_reg <= scan_more;
                if (scan_more)
                begin
                    scan_ptr_reg <= scan_ptr_reg + CW'(1);
                end
            end
            wpend_reg <= cmd.shift_step;
        end
    end

    // Item, hit and shift pointer registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start_item)
        begin
            kind_reg <= in_kind;
            off_reg  <= in_range_start;
            len_reg  <= in_range_length;
            idx_reg  <= in_entry_index;
        end
        if (cmd.scan_step && scan_more)
        begin
            chk_ptr_reg <= scan_ptr_reg[IW-1:0];
        end
        if (cmd.scan_step && chk_vld_reg)
        begin
            hit_idx_reg   <= chk_ptr_reg;
            hit_start_reg <= rd_data_reg.start;
            hit_end_reg   <= rd_end;
        end
        if (cmd.shift_init)
        begin
            rp_reg <= IW'(count_reg - CW'(1));
        end
        else if (cmd.shift_step)
        begin
            wa_reg <= rp_reg + IW'(net);
            rp_reg <= rp_reg - IW'(1);
        end
    end

    // Result register; fields that do not apply are zero.
    assign res_ok = (cmd.status == src_pkg::STAT_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.status;
            out_slot_reg   <= (res_ok && !kind_reg) ? 8'(used_slot) : 8'd0;
            out_count_reg  <= 9'(count_reg);
            out_entry_reg  <= (res_ok && kind_reg) ? rd_data_reg : '0;
        end
    end

    assign status       = out_status_reg;
    assign new_slot     = out_slot_reg;
    assign entry_count  = out_count_reg;
    assign entry_start  = out_entry_reg.start;
    assign entry_length = out_entry_reg.length;
    assign entry_used   = out_entry_reg.used;

    // The table always holds between one and the full depth of entries.
    `SRC_ASSERT(a_count_bounds, clk, rst_n, (count_reg != '0) && ((CW + 1)'(count_reg) <= (CW + 1)'(MAX_SEGMENTS)))
    // A commit grows the table by exactly the number of added pieces.
    `SRC_ASSERT_NEXT(a_commit_growth, clk, rst_n, cmd.commit && !cmd.init_table, count_reg == $past(count_reg) + CW'($past(net)))
    // Shifted entries land inside the grown table.
    `SRC_ASSERT(a_shift_in_range, clk, rst_n, !wpend_reg || ((CW + 1)'(wa_reg) < (CW + 1)'(count_reg) + (CW + 1)'(net)))

endmodule

>>> rtl/src_ctrl.sv
// src_ctrl: sequencing state machine of the segment range carver.
// Depends on src_pkg and assert_macros.svh.
`include "assert_macros.svh"

module src_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic           cfg_valid,
    input  src_pkg::stat_t stat,
    output src_pkg::cmd_t  cmd
);

    src_pkg::state_t  state_reg;
    src_pkg::state_t  state_next;
    src_pkg::status_t status_reg;
    src_pkg::status_t status_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State, pending status and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= src_pkg::S_INIT;
            status_reg    <= src_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.status     = status_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            src_pkg::S_INIT:
            begin
                cmd.init_table = 1'b1;
                state_next     = src_pkg::S_IDLE;
            end
            src_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start_item = 1'b1;
                    state_next     = src_pkg::S_START;
                end
            end
            src_pkg::S_START:
            begin
                if (stat.kind)
                begin
                    state_next = src_pkg::S_READ;
                end
                else if (stat.len_zero)
                begin
                    status_next = src_pkg::STAT_NO_FIT;
                    state_next  = src_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = src_pkg::S_SCAN;
                end
            end
            src_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = src_pkg::S_EVAL;
                end
                else if (stat.exhausted)
                begin
                    status_next = src_pkg::STAT_NO_FIT;
                    state_next  = src_pkg::S_DONE;
                end
            end
            src_pkg::S_EVAL:
            begin
                if (stat.late)
                begin
                    status_next = src_pkg::STAT_NO_FIT;
                    state_next  = src_pkg::S_DONE;
                end
                else if (stat.full)
                begin
                    status_next = src_pkg::STAT_FULL;
                    state_next  = src_pkg::S_DONE;
                end
                else if (stat.need_shift)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = src_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = stat.do_pre ? src_pkg::S_WR_PRE : src_pkg::S_WR_USED;
                end
            end
            src_pkg::S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = src_pkg::S_FLUSH;
                end
            end
            src_pkg::S_FLUSH:
            begin
                // The last shifted entry is written in this cycle.
                state_next = stat.do_pre ? src_pkg::S_WR_PRE : src_pkg::S_WR_USED;
            end
            src_pkg::S_WR_PRE:
            begin
                cmd.wr_pre = 1'b1;
                state_next = src_pkg::S_WR_USED;
            end
            src_pkg::S_WR_USED:
            begin
                cmd.wr_used = 1'b1;
                if (stat.do_rest)
                begin
                    state_next = src_pkg::S_WR_REST;
                end
                else
                begin
                    cmd.commit  = 1'b1;
                    status_next = src_pkg::STAT_OK;
                    state_next  = src_pkg::S_DONE;
                end
            end
            src_pkg::S_WR_REST:
            begin
                cmd.wr_rest = 1'b1;
                cmd.commit  = 1'b1;
                status_next = src_pkg::STAT_OK;
                state_next  = src_pkg::S_DONE;
            end
            src_pkg::S_READ:
            begin
                if (stat.idx_ok)
                begin
                    cmd.rd_issue = 1'b1;
                    status_next  = src_pkg::STAT_OK;
                end
                else
                begin
                    status_next = src_pkg::STAT_BAD_INDEX;
                end
                state_next = src_pkg::S_DONE;
            end
            src_pkg::S_DONE:
            begin
                // Wait until the result register is free, then load it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = src_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = src_pkg::S_INIT;
            end
        endcase

        // A region size write restarts the table.
        if (cfg_valid)
        begin
            state_next = src_pkg::S_INIT;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted item always starts processing.
    `SRC_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready && !cfg_valid, state_reg == src_pkg::S_START)
    // A configuration write always rebuilds the table next.
    `SRC_ASSERT_NEXT(a_cfg_restarts, clk, rst_n, cfg_valid, state_reg == src_pkg::S_INIT)
    // Loading a result always raises the result valid.
    `SRC_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, out_valid_reg)

endmodule

>>> rtl/segment_range_carver.sv
// segment_range_carver: top level joining the controller and the datapath.
// Depends on src_pkg, the three channel interfaces, src_ctrl and src_datapath.
//
// request carries one item: kind 0 carves [range_start, range_start +
// range_length) out of the first covering free segment, kind 1 reads the
// table entry at entry_index. Each item gives exactly one result item with
// status, new_slot, entry_count and the read entry fields. cfg writes the
// region size; the write is always taken and restarts the table as one free
// segment. Write it only while no item is in flight.
// A carve scans S entries, moves H entries up to open a gap and makes W
// piece writes (one to three), one per cycle. The scan stops where the
// move begins, so S + H is at most the entry count.
// One item is worked on at a time; the next is accepted once the previous
// result is loaded, even while that result waits to be taken.
// After reset, or a region size write, the S_INIT state rebuilds slot 0 before
// request is ready. A stalled result holds its payload; the block then
// finishes the next item and waits to load it.
module segment_range_carver #(
    parameter int MAX_SEGMENTS = src_pkg::MAX_SEGMENTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    src_req_if.sink request,
    src_res_if.source result,
    src_cfg_if.sink cfg
);

    src_pkg::cmd_t  cmd;
    src_pkg::stat_t stat;

    // The region size register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencing.
    src_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cfg_valid (cfg.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table storage and arithmetic.
    src_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg.valid),
        .cfg_region_size (cfg.region_size),
        .in_kind         (request.kind),
        .in_range_start  (request.range_start),
        .in_range_length (request.range_length),
        .in_entry_index  (request.entry_index),
        .status          (result.status),
        .new_slot        (result.new_slot),
        .entry_count     (result.entry_count),
        .entry_start     (result.entry_start),
        .entry_length    (result.entry_length),
        .entry_used      (result.entry_used)
    );

endmodule

>>> verif/tb_segment_range_carver.sv
// Self-checking testbench for segment_range_carver: carve and read items are checked
// against an in-bench segment table predictor. Depends on src_pkg, src_req_if,
// src_res_if, src_cfg_if and the segment_range_carver RTL.
`timescale 1ns / 100ps

module tb_segment_range_carver;

    localparam int MAX_SEG = src_pkg::MAX_SEGMENTS_DEF;
    localparam logic KIND_CARVE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // One request item as driven on the request channel.
    typedef struct packed {
        logic        kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [7:0]  index;
    } carve_req_t;

    // One result item as seen on the result channel.
    typedef struct packed {
        src_pkg::status_t status;
        logic [7:0]       new_slot;
        logic [8:0]       count;
        logic [31:0]      start;
        logic [31:0]      length;
        logic             used;
    } carve_res_t;

    logic clk;
    logic rst_n;

    src_req_if req_bus ();
    src_res_if res_bus ();
    src_cfg_if cfg_bus ();

    segment_range_carver uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus),
        .cfg     (cfg_bus)
    );

    // Predictor state: the segment table as the block should hold it.
    src_pkg::entry_t seg_tab [MAX_SEG];
    int              seg_count;

    carve_req_t pending_items [$];
    carve_res_t due_results [$];
    int         items_out;
    int         mismatches;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       req_taken;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Rebuild the table as one free segment over the whole region.
    function automatic void restart_table(input logic [31:0] region_len);
        for (int i = 0; i < MAX_SEG; i++)
        begin
            seg_tab[i] = '0;
        end
        seg_tab[0].length = region_len;
        seg_count = 1;
    endfunction

    // Work out the result of one item and update the table the same way the block must.
    function automatic carve_res_t predict_carve_read(input carve_req_t it);
        carve_res_t  r;
        logic [32:0] want_end;
        logic [32:0] seg_end;
        logic [32:0] rest;
        logic [31:0] s;
        logic        pre;
        logic        found;
        int          net;
        int          slot;
        r = '0;
        r.status = src_pkg::STAT_OK;
        if (it.kind == KIND_CARVE)
        begin
            r.status = src_pkg::STAT_NO_FIT;
            want_end = {1'b0, it.start} + {1'b0, it.length};
            // A zero length carve never finds a segment.
            found = (it.length == 32'd0);
            for (int i = 0; i < seg_count && !found; i++)
            begin
                seg_end = {1'b0, seg_tab[i].start} + {1'b0, seg_tab[i].length};
                if (!seg_tab[i].used && seg_end >= want_end)
                begin
                    found = 1'b1;
                    s = seg_tab[i].start;
                    // The first covering free segment must not start after the range.
                    if (s <= it.start)
                    begin
                        pre = (s < it.start);
                        rest = seg_end - want_end;
                        net = int'(pre) + int'(rest != 33'd0);
                        if (seg_count + net > MAX_SEG)
                        begin
                            r.status = src_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // Open a gap after the split segment, then write the pieces.
                            for (int j = seg_count - 1; j > i; j--)
                            begin
                                seg_tab[j + net] = seg_tab[j];
                            end
                            slot = i;
                            if (pre)
                            begin
                                seg_tab[slot] = '{start: s, length: it.start - s, used: 1'b0};
                                slot++;
                            end
                            seg_tab[slot] = '{start: it.start, length: it.length, used: 1'b1};
                            if (rest != 33'd0)
                            begin
                                seg_tab[slot + 1] = '{start: want_end[31:0], length: rest[31:0],
                                                      used: 1'b0};
                            end
                            seg_count += net;
                            r.status = src_pkg::STAT_OK;
                            r.new_slot = slot[7:0];
                        end
                    end
                end
            end
        end
        else if (int'(it.index) < seg_count)
        begin
            r.start = seg_tab[it.index].start;
            r.length = seg_tab[it.index].length;
            r.used = seg_tab[it.index].used;
        end
        else
        begin
            r.status = src_pkg::STAT_BAD_INDEX;
        end
        r.count = seg_count[8:0];
        return r;
    endfunction

    function automatic carve_req_t mk_carve(input logic [31:0] off, input logic [31:0] len);
        return '{kind: KIND_CARVE, start: off, length: len, index: 8'($urandom)};
    endfunction

    function automatic carve_req_t mk_read(input logic [7:0] idx);
        return '{kind: KIND_READ, start: $urandom, length: $urandom, index: idx};
    endfunction

    // Arbitrary item: a carve or a read at random, with short and zero lengths mixed in.
    function automatic carve_req_t noise_item();
        carve_req_t it;
        it.kind = 1'($urandom);
        it.start = $urandom;
        it.length = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 8);
        it.index = 8'($urandom);
        return it;
    endfunction

    // Carve that fits inside a free segment: whole, start aligned, end aligned or middle.
    function automatic carve_req_t pick_fitting_carve();
        int          free_slots [$];
        int          pick;
        logic [31:0] s;
        logic [31:0] seg_len;
        logic [31:0] limit;
        logic [31:0] room;
        logic [31:0] off;
        logic [31:0] len;
        for (int i = 0; i < seg_count; i++)
        begin
            if (!seg_tab[i].used && seg_tab[i].length != 32'd0)
            begin
                free_slots.push_back(i);
            end
        end
        if (free_slots.size() == 0)
        begin
            return noise_item();
        end
        pick = free_slots[$urandom_range(0, free_slots.size() - 1)];
        s = seg_tab[pick].start;
        seg_len = seg_tab[pick].length;
        // Keep lengths short half of the time so the region lasts longer.
        limit = ($urandom_range(0, 1) == 0 && seg_len > 32'd64) ? 32'd64 : seg_len;
        case ($urandom_range(0, 3))
            0:
            begin
                off = s;
                len = seg_len;
            end
            1:
            begin
                off = s;
                len = $urandom_range(1, limit);
            end
            2:
            begin
                len = $urandom_range(1, limit);
                off = s + seg_len - len;
            end
            default:
            begin
                off = s + $urandom_range(0, seg_len - 1);
                room = seg_len - (off - s);
                len = $urandom_range(1, (room < limit) ? room : limit);
            end
        endcase
        return mk_carve(off, len);
    endfunction

    // Carve that starts inside a used segment, so the covering free segment starts late.
    function automatic carve_req_t pick_late_carve();
        int used_slots [$];
        int pick;
        for (int i = 0; i < seg_count; i++)
        begin
            if (seg_tab[i].used)
            begin
                used_slots.push_back(i);
            end
        end
        if (used_slots.size() == 0)
        begin
            return noise_item();
        end
        pick = used_slots[$urandom_range(0, used_slots.size() - 1)];
        return mk_carve(seg_tab[pick].start + $urandom_range(0, seg_tab[pick].length - 1),
                        $urandom_range(1, 32));
    endfunction

    function automatic carve_req_t random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return pick_fitting_carve();
        end
        if (roll < 70)
        begin
            return mk_read(8'($urandom_range(0, seg_count - 1)));
        end
        if (roll < 75 && seg_count < MAX_SEG)
        begin
            return mk_read(8'($urandom_range(seg_count, MAX_SEG - 1)));
        end
        if (roll < 82)
        begin
            return pick_late_carve();
        end
        return noise_item();
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Queue one item once the previous one has been taken, so generators see a fresh table.
    task automatic push_item(input carve_req_t it);
        while (items_out != 0)
        begin
            @(negedge clk);
        end
        pending_items.push_back(it);
        items_out++;
    endtask

    task automatic wait_drained();
        while (items_out != 0 || due_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Write the region size while the block is idle.
    task automatic set_region(input logic [31:0] region_len);
        wait_drained();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.region_size <= region_len;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        restart_table(region_len);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Request driver: presents queued items at the falling edge and holds each until taken.
    always @(negedge clk)
    begin : req_driver
        carve_req_t nxt;
        if (rst_n)
        begin
            if (!req_bus.valid || req_taken)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.kind <= nxt.kind;
                    req_bus.range_start <= nxt.start;
                    req_bus.range_length <= nxt.length;
                    req_bus.entry_index <= nxt.index;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts each accepted item and checks each accepted result in order.
    always @(posedge clk)
    begin : monitor
        carve_req_t taken;
        carve_res_t got;
        carve_res_t want;
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            taken = '{kind: req_bus.kind, start: req_bus.range_start,
                      length: req_bus.range_length, index: req_bus.entry_index};
            due_results.push_back(predict_carve_read(taken));
            items_out--;
        end
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{status: src_pkg::status_t'(res_bus.status), new_slot: res_bus.new_slot,
                    count: res_bus.entry_count, start: res_bus.entry_start,
                    length: res_bus.entry_length, used: res_bus.entry_used};
            if (due_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", 32'(got.status), 32'd0);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                begin
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                end
                if (got.new_slot !== want.new_slot)
                begin
                    report_mismatch("new_slot", 32'(got.new_slot), 32'(want.new_slot));
                end
                if (got.count !== want.count)
                begin
                    report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                end
                if (got.start !== want.start)
                begin
                    report_mismatch("entry_start", got.start, want.start);
                end
                if (got.length !== want.length)
                begin
                    report_mismatch("entry_length", got.length, want.length);
                end
                if (got.used !== want.used)
                begin
                    report_mismatch("entry_used", 32'(got.used), 32'(want.used));
                end
            end
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        req_bus.valid = 1'b0;
        req_bus.kind = KIND_CARVE;
        req_bus.range_start = '0;
        req_bus.range_length = '0;
        req_bus.entry_index = '0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.region_size = '0;
        req_taken = 1'b0;
        items_out = 0;
        mismatches = 0;
        send_idle_pct = 6;
        recv_stall_pct = 85;
        restart_table(32'd0);
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty region after reset: every carve misses.
        push_item(mk_carve(32'd0, 32'd1));
        push_item(mk_read(8'd0));
        push_item(mk_read(8'd1));

        // Full 32-bit region: splits, late start, end at the top of the range.
        set_region(32'hFFFF_FFFF);
        push_item(mk_read(8'd0));
        push_item(mk_carve(32'd0, 32'd0));
        push_item(mk_carve(32'h10, 32'h10));
        push_item(mk_carve(32'h18, 32'h10));
        push_item(mk_carve(32'hFFFF_FF00, 32'h100));
        push_item(mk_carve(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_item(mk_carve(32'd0, 32'h10));
        for (int i = 0; i < 5; i++)
        begin
            push_item(mk_read(8'(i)));
        end
        push_item(mk_read(8'hFF));

        // One byte region: the first carve takes the whole segment, the second misses.
        set_region(32'd1);
        push_item(mk_carve(32'd0, 32'd1));
        push_item(mk_carve(32'd0, 32'd1));

        // Hit the full case one slot short, fill the last slot, then carve with no growth.
        set_region(32'd1_000_000);
        for (int k = 0; k < 127; k++)
        begin
            push_item(mk_carve(32'(4 * k + 1), 32'd2));
        end
        push_item(mk_carve(32'(4 * 127 + 1), 32'd2));
        push_item(mk_carve(32'(4 * 127 - 1), 32'd1));
        push_item(mk_read(8'hFF));
        push_item(mk_carve(32'(4 * 127), 32'd1));
        push_item(mk_carve(32'd3, 32'd2));

        // Random items under each idling pattern and several region sizes.
        for (int m = 0; m < 3; m++)
        begin
            wait_drained();
            send_idle_pct = (m == 0) ? 6 : (m == 1) ? 85 : 0;
            recv_stall_pct = (m == 0) ? 85 : (m == 1) ? 6 : 0;
            for (int j = 0; j < 4; j++)
            begin
                case (j)
                    0: set_region(32'hFFFF_FFFF);
                    1: set_region($urandom_range(1, 64));
                    2: set_region($urandom);
                    default: set_region($urandom_range(65, 4096));
                endcase
                repeat (83)
                begin
                    push_item(random_item());
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
